### src/mixed_radix_residue_converter_defines.svh
// Assertion macros for the mixed-radix residue converter.
`ifndef MIXED_RADIX_RESIDUE_CONVERTER_DEFINES_SVH
`define MIXED_RADIX_RESIDUE_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MRRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MRRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/mrrc_pkg.sv
// Shared types, constants and helper functions of the mixed-radix residue converter.
package mrrc_pkg;

  localparam int LANES = 6;
  localparam int VW    = 15;

  typedef logic [VW-1:0] val_t;
  typedef logic [LANES-1:0][VW-1:0] vec_t;

  typedef struct packed {
    logic action;
    val_t value_0;
    val_t value_1;
    val_t value_2;
    val_t value_3;
    val_t value_4;
    val_t value_5;
  } in_word_t;

  typedef struct packed {
    val_t result_0;
    val_t result_1;
    val_t result_2;
    val_t result_3;
    val_t result_4;
    val_t result_5;
  } out_word_t;

  // Per-cell constants, all derived from the configuration registers.
  typedef struct packed {
    val_t        my;
    val_t        mx;
    logic [31:0] mu;
    logic [15:0] pad;
    val_t        inv;
    logic        act;
  } cell_cfg_t;

  localparam logic ACT_DECOMPOSE = 1'b0;
  localparam logic ACT_COMPOSE   = 1'b1;

  localparam logic [2:0] REG_IN_USE = 3'd6;

  localparam vec_t MOD_RESET = {15'd13, 15'd11, 15'd7, 15'd5, 15'd3, 15'd2};
  localparam logic [2:0] IN_USE_RESET = 3'd6;

  // Lane pair handled by cell p, in the order x then y > x.
  function automatic int pair_x(int p, int nm);
    int c;
    int r;
    c = 0;
    r = 0;
    for (int x = 0; x < nm; x++) begin
      for (int y = x + 1; y < nm; y++) begin
        if (c == p) r = x;
        c++;
      end
    end
    return r;
  endfunction

  function automatic int pair_y(int p, int nm);
    int c;
    int r;
    c = 0;
    r = 0;
    for (int x = 0; x < nm; x++) begin
      for (int y = x + 1; y < nm; y++) begin
        if (c == p) r = y;
        c++;
      end
    end
    return r;
  endfunction

endpackage

### src/mixed_radix_residue_converter.sv
// Top level of the mixed-radix residue converter: registers, setup sequencer, cell chain.
// Converts a six-lane vector between residues and mixed-radix digits (Garner) in a
// chain of NUM_MODULI*(NUM_MODULI-1)/2 cells, one per lane pair, each four stages
// deep. One word is taken per cycle while in_stall is low. After reset and after every
// modulus write, a sequencer derives Barrett reciprocals and Fermat inverses with one
// shared multiplier; in_stall stays high while the sequencer runs, and for the access
// cycle of the write as well. Writes to moduli_in_use take effect at once.
`include "mixed_radix_residue_converter_defines.svh"

module mixed_radix_residue_converter #(
  parameter int NUM_MODULI = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrrc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mrrc_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NP = NUM_MODULI * (NUM_MODULI - 1) / 2;

  mrrc_pkg::vec_t mod_r;
  logic [2:0]     n_r;
  logic [2:0]     reg_idx;
  logic           wr;
  logic           wr_mod;
  logic           setup_busy;
  logic           advance;

  logic [mrrc_pkg::LANES-1:0][31:0]       mu;
  logic [mrrc_pkg::LANES-1:0][15:0]       pad;
  logic [NP-1:0][mrrc_pkg::VW-1:0]        inv;

  logic [NP:0]    ch_valid;
  logic [NP:0]    ch_action;
  mrrc_pkg::vec_t ch_vec [NP+1];

  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite;
  assign wr_mod  = wr && (reg_idx < 3'(mrrc_pkg::LANES));
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= mrrc_pkg::MOD_RESET;
      n_r   <= mrrc_pkg::IN_USE_RESET;
    end else if (wr) begin
      if (reg_idx < 3'(mrrc_pkg::LANES)) begin
        mod_r[reg_idx] <= pwdata[14:0];
      end else if (reg_idx == mrrc_pkg::REG_IN_USE) begin
        n_r <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (reg_idx < 3'(mrrc_pkg::LANES)) begin
      prdata = {17'd0, mod_r[reg_idx]};
    end else if (reg_idx == mrrc_pkg::REG_IN_USE) begin
      prdata = {29'd0, n_r};
    end else begin
      prdata = 32'd0;
    end
  end

  mrrc_setup #(
    .NUM_MODULI (NUM_MODULI)
  ) u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wr_mod),
    .mods  (mod_r),
    .busy  (setup_busy),
    .mu_o  (mu),
    .pad_o (pad),
    .inv_o (inv)
  );

  // The last cell's final stage doubles as the output register.
  assign advance   = !ch_valid[NP] || !out_stall;
  assign in_stall  = setup_busy || wr_mod || !advance;

  assign ch_valid[0]  = in_valid && !in_stall;
  assign ch_action[0] = in_data.action;
  assign ch_vec[0]    = {in_data.value_5, in_data.value_4, in_data.value_3,
                         in_data.value_2, in_data.value_1, in_data.value_0};

  for (genvar p = 0; p < NP; p++) begin : g_cell
    localparam int CX = mrrc_pkg::pair_x(p, NUM_MODULI);
    localparam int CY = mrrc_pkg::pair_y(p, NUM_MODULI);
    mrrc_pkg::cell_cfg_t ccfg;

    assign ccfg.my  = mod_r[CY];
    assign ccfg.mx  = mod_r[CX];
    assign ccfg.mu  = mu[CY];
    assign ccfg.pad = pad[CY];
    assign ccfg.inv = inv[p];
    assign ccfg.act = (n_r > 3'(CY));

    mrrc_cell #(
      .X (CX),
      .Y (CY)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .cfg       (ccfg),
      .up_valid  (ch_valid[p]),
      .up_vec    (ch_vec[p]),
      .up_action (ch_action[p]),
      .dn_valid  (ch_valid[p+1]),
      .dn_vec    (ch_vec[p+1]),
      .dn_action (ch_action[p+1])
    );
  end

  assign out_valid         = ch_valid[NP];
  assign out_data.result_0 = ch_vec[NP][0];
  assign out_data.result_1 = ch_vec[NP][1];
  assign out_data.result_2 = ch_vec[NP][2];
  assign out_data.result_3 = ch_vec[NP][3];
  assign out_data.result_4 = ch_vec[NP][4];
  assign out_data.result_5 = ch_vec[NP][5];

  `MRRC_ASSERT_IMPL(a_setup_after_reset, !$past(rst_n), setup_busy && in_stall, "setup not running after reset")
  `MRRC_ASSERT_NEXT(a_setup_on_write, wr_mod, setup_busy && in_stall, "setup not restarted by modulus write")

endmodule

### src/mrrc_setup.sv
// Sequencer that derives reciprocals, offsets and modular inverses from the moduli.
module mrrc_setup #(
  parameter int NUM_MODULI = 6
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  mrrc_pkg::vec_t                         mods,
  output logic                                   busy,
  output logic [mrrc_pkg::LANES-1:0][31:0]       mu_o,
  output logic [mrrc_pkg::LANES-1:0][15:0]       pad_o,
  output logic [NUM_MODULI*(NUM_MODULI-1)/2-1:0][mrrc_pkg::VW-1:0] inv_o
);

  localparam int NP  = NUM_MODULI * (NUM_MODULI - 1) / 2;
  localparam int PIW = (NP > 1) ? $clog2(NP) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_MULR = 3'd3;
  localparam logic [2:0] S_MULB = 3'd4;

  logic [2:0]     state_r;
  logic [2:0]     yi_r;
  logic [5:0]     dstep_r;
  logic [15:0]    rem_r;
  logic [31:0]    quo_r;
  logic [PIW-1:0] pi_r;
  logic [2:0]     px_r;
  logic [2:0]     py_r;
  logic [3:0]     it_r;
  logic [1:0]     ph_r;

  logic [mrrc_pkg::LANES-1:0][31:0] mu_r;
  logic [mrrc_pkg::LANES-1:0][15:0] pad_r;
  logic [NP-1:0][mrrc_pkg::VW-1:0]  inv_r;

  logic [29:0]          mt_r;
  logic [29:0]          mq_r;
  logic [29:0]          mqm_r;
  mrrc_pkg::val_t       br_r;
  mrrc_pkg::val_t       rr_r;
  mrrc_pkg::val_t       e_r;

  mrrc_pkg::val_t div_m;
  logic [15:0]    shifted;
  logic           ge;
  logic [15:0]    rem_nxt;
  logic [15:0]    pad_val;

  mrrc_pkg::val_t mm_m;
  logic [31:0]    mm_mu;
  mrrc_pkg::val_t mm_a;
  mrrc_pkg::val_t mm_b;
  logic [61:0]    mm_prod;
  logic [29:0]    mm_diff;
  mrrc_pkg::val_t mm_res;
  logic           mm_done;
  logic           mm_state;

  // Restoring division of 2**32 by the modulus, one quotient bit a cycle.
  always_comb begin
    div_m   = mods[yi_r];
    shifted = {rem_r[14:0], (dstep_r == 6'd0)};
    ge      = shifted >= {1'b0, div_m};
    rem_nxt = ge ? (shifted - {1'b0, div_m}) : shifted;
    // After sixteen dividend bits the remainder is 2**15 mod m.
    pad_val = (rem_nxt == 16'd0) ? 16'h8000 : (16'h8000 + {1'b0, div_m} - rem_nxt);
  end

  // Barrett modular multiply in phases: product, quotient estimate, quotient times modulus, correction.
  always_comb begin
    mm_m  = mods[py_r];
    mm_mu = mu_r[py_r];
    case (state_r)
      S_BASE: begin
        mm_a = mods[px_r];
        mm_b = 15'd1;
      end
      S_MULR: begin
        mm_a = rr_r;
        mm_b = br_r;
      end
      default: begin
        mm_a = br_r;
        mm_b = br_r;
      end
    endcase
    mm_prod  = 62'(mt_r) * 62'(mm_mu);
    mm_diff  = mt_r - mqm_r;
    mm_res   = (mm_diff >= 30'(mm_m)) ? 15'(mm_diff - 30'(mm_m)) : mm_diff[14:0];
    mm_done  = (ph_r == 2'd3);
    mm_state = (state_r == S_BASE) || (state_r == S_MULR) || (state_r == S_MULB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      state_r <= S_DIV;
      yi_r    <= 3'd0;
      dstep_r <= 6'd0;
      rem_r   <= 16'd0;
      ph_r    <= 2'd0;
      pi_r    <= '0;
      px_r    <= 3'd0;
      py_r    <= 3'd1;
      it_r    <= 4'd0;
    end else begin
      case (state_r)
        S_DIV: begin
          rem_r <= rem_nxt;
          if (dstep_r == 6'd32) begin
            dstep_r <= 6'd0;
            rem_r   <= 16'd0;
            if (yi_r == 3'(NUM_MODULI - 1)) begin
              state_r <= S_BASE;
              pi_r    <= '0;
              px_r    <= 3'd0;
              py_r    <= 3'd1;
            end else begin
              yi_r <= yi_r + 3'd1;
            end
          end else begin
            dstep_r <= dstep_r + 6'd1;
          end
        end
        S_BASE: begin
          ph_r <= ph_r + 2'd1;
          if (mm_done) begin
            state_r <= S_MULR;
            it_r    <= 4'd0;
          end
        end
        S_MULR: begin
          ph_r <= ph_r + 2'd1;
          if (mm_done) state_r <= S_MULB;
        end
        S_MULB: begin
          ph_r <= ph_r + 2'd1;
          if (mm_done) begin
            if (it_r == 4'd14) begin
              if (pi_r == PIW'(NP - 1)) begin
                state_r <= S_IDLE;
              end else begin
                pi_r    <= pi_r + PIW'(1);
                state_r <= S_BASE;
                if (py_r == 3'(NUM_MODULI - 1)) begin
                  px_r <= px_r + 3'd1;
                  py_r <= px_r + 3'd2;
                end else begin
                  py_r <= py_r + 3'd1;
                end
              end
            end else begin
              it_r    <= it_r + 4'd1;
              state_r <= S_MULR;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV) begin
      quo_r <= {quo_r[30:0], ge};
      if (dstep_r == 6'd15) pad_r[yi_r] <= pad_val;
      if (dstep_r == 6'd32) mu_r[yi_r] <= {quo_r[30:0], ge};
    end
    if (mm_state) begin
      case (ph_r)
        2'd0: mt_r <= 30'(mm_a) * 30'(mm_b);
        2'd1: mq_r <= mm_prod[61:32];
        2'd2: mqm_r <= 30'(mq_r * 30'(mm_m));
        default: begin
          case (state_r)
            S_BASE: begin
              br_r <= mm_res;
              rr_r <= 15'd1;
              e_r  <= mm_m - 15'd2;
            end
            S_MULR: begin
              if (e_r[0]) rr_r <= mm_res;
            end
            default: begin
              br_r <= mm_res;
              e_r  <= e_r >> 1;
              if (it_r == 4'd14) inv_r[pi_r] <= rr_r;
            end
          endcase
        end
      endcase
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign mu_o  = mu_r;
  assign pad_o = pad_r;
  assign inv_o = inv_r;

endmodule

### src/mrrc_cell.sv
// One conversion cell: updates lane Y from lane X in four pipeline stages.
module mrrc_cell #(
  parameter int X = 0,
  parameter int Y = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  mrrc_pkg::cell_cfg_t cfg,
  input  logic                up_valid,
  input  mrrc_pkg::vec_t      up_vec,
  input  logic                up_action,
  output logic                dn_valid,
  output mrrc_pkg::vec_t      dn_vec,
  output logic                dn_action
);

  logic [3:0] val_r;
  mrrc_pkg::vec_t vec1_r, vec2_r, vec3_r, vec4_r;
  logic act1_r, act2_r, act3_r, act4_r;
  logic [31:0] t1_r, t2_r, t3_r;
  logic [31:0] q2_r;
  logic [31:0] qm3_r;

  mrrc_pkg::val_t vy;
  mrrc_pkg::val_t vx;
  logic [29:0]    prod_c;
  logic [31:0]    t_c;
  logic [16:0]    s_d;
  logic [31:0]    t_d;
  logic [63:0]    prod_q;
  logic [46:0]    prod_qm;
  logic [31:0]    diff;
  mrrc_pkg::val_t red;
  mrrc_pkg::val_t lane_nxt;
  mrrc_pkg::vec_t vec4_nxt;

  always_comb begin
    vy     = up_vec[Y];
    vx     = up_vec[X];
    prod_c = 30'(vy) * 30'(cfg.mx);
    t_c    = 32'(prod_c) + 32'(vx);
    // Adding a multiple of m_y at least 2**15 keeps the difference non-negative.
    s_d    = 17'(vy) + 17'(cfg.pad) - 17'(vx);
    t_d    = 32'(s_d) * 32'(cfg.inv);
    prod_q = 64'(t1_r) * 64'(cfg.mu);
    prod_qm = 47'(q2_r) * 47'(cfg.my);
    diff   = t3_r - qm3_r;
    red    = (diff[16:0] >= 17'(cfg.my)) ? 15'(diff[16:0] - 17'(cfg.my)) : diff[14:0];
    if (!cfg.act || (cfg.my == 15'd0)) begin
      lane_nxt = vec3_r[Y];
    end else if (cfg.my == 15'd1) begin
      lane_nxt = 15'd0;
    end else begin
      lane_nxt = red;
    end
    vec4_nxt    = vec3_r;
    vec4_nxt[Y] = lane_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 4'd0;
    end else if (en) begin
      val_r <= {val_r[2:0], up_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1_r <= up_vec;
      act1_r <= up_action;
      t1_r   <= (up_action == mrrc_pkg::ACT_COMPOSE) ? t_c : t_d;
      vec2_r <= vec1_r;
      act2_r <= act1_r;
      t2_r   <= t1_r;
      q2_r   <= prod_q[63:32];
      vec3_r <= vec2_r;
      act3_r <= act2_r;
      t3_r   <= t2_r;
      qm3_r  <= prod_qm[31:0];
      vec4_r <= vec4_nxt;
      act4_r <= act3_r;
    end
  end

  assign dn_valid  = val_r[3];
  assign dn_vec    = vec4_r;
  assign dn_action = act4_r;

endmodule

### tb/testbench.sv
// Self-checking testbench of the mixed-radix residue converter.
module testbench;

  localparam int NM = 6;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mrrc_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  mrrc_pkg::out_word_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mixed_radix_residue_converter #(.NUM_MODULI(NM)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the configuration registers.
  logic [14:0] moduli[NM];
  logic [2:0] in_use;

  mrrc_pkg::in_word_t pending_words[$];
  mrrc_pkg::out_word_t expected_results[$];
  int errors;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;
  bit in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [14:0] pow_mod(logic [14:0] b, int e, int m);
    longint r;
    longint bb;
    r = 1 % m;
    bb = longint'(b) % m;
    while (e != 0) begin
      if (e & 1) r = (r * bb) % m;
      bb = (bb * bb) % m;
      e = e >> 1;
    end
    return r[14:0];
  endfunction

  function automatic mrrc_pkg::out_word_t convert(mrrc_pkg::in_word_t w);
    longint v[NM];
    longint my;
    longint mx;
    longint d;
    longint inv;
    int n;
    mrrc_pkg::out_word_t r;
    n = (int'(in_use) > NM) ? NM : int'(in_use);
    v[0] = longint'(w.value_0); v[1] = longint'(w.value_1); v[2] = longint'(w.value_2);
    v[3] = longint'(w.value_3); v[4] = longint'(w.value_4); v[5] = longint'(w.value_5);
    for (int x = 0; x < n; x++) begin
      for (int y = x + 1; y < n; y++) begin
        my = longint'(moduli[y]);
        mx = longint'(moduli[x]);
        if (my != 0) begin
          if (w.action == mrrc_pkg::ACT_COMPOSE) begin
            v[y] = (v[y] * mx + v[x]) % my;
          end else begin
            d = (v[y] % my + my - v[x] % my) % my;
            inv = (my >= 2) ? longint'(pow_mod(mx[14:0], int'(my) - 2, int'(my))) : 0;
            v[y] = (d * inv) % my;
          end
        end
      end
    end
    r.result_0 = v[0][14:0]; r.result_1 = v[1][14:0]; r.result_2 = v[2][14:0];
    r.result_3 = v[3][14:0]; r.result_4 = v[4][14:0]; r.result_5 = v[5][14:0];
    return r;
  endfunction

  // Driver: offers words from the pending queue at random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off while hold_cycles is nonzero.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_results.push_back(convert(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        mrrc_pkg::out_word_t e;
        e = expected_results.pop_front();
        if (e != out_data) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(int idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(4 * idx); pwdata <= val; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < NM) moduli[idx] = val[14:0];
    else in_use = val[2:0];
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic mrrc_pkg::in_word_t rand_word(int lim);
    mrrc_pkg::in_word_t w;
    w.action = 1'($urandom_range(1));
    w.value_0 = 15'($urandom_range(lim)); w.value_1 = 15'($urandom_range(lim));
    w.value_2 = 15'($urandom_range(lim)); w.value_3 = 15'($urandom_range(lim));
    w.value_4 = 15'($urandom_range(lim)); w.value_5 = 15'($urandom_range(lim));
    return w;
  endfunction

  task automatic run_phase(int count, int lim);
    for (int i = 0; i < count; i++) pending_words.push_back(rand_word(lim));
    drain();
  endtask

  task automatic set_moduli(int a, int b, int c, int d, int e, int f, int u);
    reg_write(0, a); reg_write(1, b); reg_write(2, c);
    reg_write(3, d); reg_write(4, e); reg_write(5, f);
    reg_write(int'(mrrc_pkg::REG_IN_USE), u);
  endtask

  initial begin
    mrrc_pkg::in_word_t w;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; send_idle_pct = 0; stall_pct = 0; hold_cycles = 0; in_taken = 1'b0;
    for (int i = 0; i < NM; i++) moduli[i] = mrrc_pkg::MOD_RESET[i];
    in_use = mrrc_pkg::IN_USE_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at reset moduli: extremes and both actions.
    for (int a = 0; a < 2; a++) begin
      w = '0; w.action = 1'(a); pending_words.push_back(w);
      w = '1; w.action = 1'(a); pending_words.push_back(w);
      w = {1'b0, 15'd1, 15'd2, 15'd4, 15'd6, 15'd10, 15'd12}; w.action = 1'(a);
      pending_words.push_back(w);
      w = {1'b0, 15'h5555, 15'h2aaa, 15'h5555, 15'h2aaa, 15'h5555, 15'h2aaa};
      w.action = 1'(a);
      pending_words.push_back(w);
    end
    drain();

    // Large primes, all lanes, no idling, with a long output hold-off once the
    // derived constants are ready, so that the chain fills and stalls its input.
    set_moduli(32749, 32719, 32717, 32713, 32707, 32693, 6);
    while (in_stall) @(negedge clk);
    hold_cycles = 300;
    run_phase(250, 32767);
    send_idle_pct = 58;
    run_phase(200, 32767);
    stall_pct = 58; send_idle_pct = 0;
    set_moduli(2, 3, 5, 7, 11, 13, 7);
    run_phase(200, 32767);
    send_idle_pct = 25; stall_pct = 25;
    set_moduli(1, 0, 32767, 4, 1, 6, 4);
    run_phase(150, 32767);
    send_idle_pct = 0; stall_pct = 0;
    set_moduli(101, 32749, 2, 127, 8191, 3, 1);
    run_phase(80, 32767);
    set_moduli(101, 32749, 3, 127, 8191, 5, 0);
    run_phase(80, 32767);
    send_idle_pct = 58; stall_pct = 58;
    set_moduli(17, 19, 23, 29, 31, 37, 3);
    run_phase(130, 63);
    send_idle_pct = 25; stall_pct = 25;
    set_moduli(97, 89, 83, 79, 73, 71, 6);
    run_phase(150, 127);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
